### rtl/pms_pkg.sv
`default_nettype none
package pms_pkg;

   // Q15.8 component
   typedef logic signed [23:0] q_type;

   localparam q_type Q_MAX = 24'sh7FFFFF;
   localparam q_type Q_MIN = 24'sh800000;

   // opcodes of an input word
   localparam logic [1:0] OP_FORCE = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_PLACE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
   localparam logic [2:0] REG_DECAY       = 3'd1;
   localparam logic [2:0] REG_RADIUS      = 3'd2;
   localparam logic [2:0] REG_LEFT        = 3'd3;
   localparam logic [2:0] REG_TOP         = 3'd4;
   localparam logic [2:0] REG_RIGHT       = 3'd5;
   localparam logic [2:0] REG_BOTTOM      = 3'd6;

   // configuration reset values
   localparam logic [22:0] RST_SPEED_LIMIT = 23'd1280;
   localparam logic [16:0] RST_DECAY       = 17'd62259;
   localparam logic [22:0] RST_RADIUS      = 23'd2560;
   localparam q_type       RST_LEFT        = 24'sd0;
   localparam q_type       RST_TOP         = 24'sd0;
   localparam q_type       RST_RIGHT       = 24'sd163840;
   localparam q_type       RST_BOTTOM      = 24'sd122880;

   // sequencer step counts (last step index)
   localparam logic [5:0] SQ_LAST    = 6'd3;
   localparam logic [5:0] SQRT_LAST  = 6'd23;
   localparam logic [5:0] DIV_LAST   = 6'd47;
   localparam logic [47:0] SQRT_BIT0 = 48'h4000_0000_0000;

   // saturating add of two components
   function automatic q_type sat_add(input q_type a, input q_type b);
      logic signed [24:0] s;
      s = {a[23], a} + {b[23], b};
      if (s[24] != s[23]) begin
         return s[24] ? Q_MIN : Q_MAX;
      end
      return s[23:0];
   endfunction

   // saturate a 26-bit signed value into a component
   function automatic q_type sat_wide(input logic signed [25:0] v);
      if (v > 26'sd8388607) begin
         return Q_MAX;
      end
      if (v < -26'sd8388608) begin
         return Q_MIN;
      end
      return v[23:0];
   endfunction

   // apply a sign to a magnitude, saturated
   function automatic q_type sat_mag(input logic neg, input logic [47:0] mag);
      if (!neg) begin
         return (mag > 48'h7FFFFF) ? Q_MAX : mag[23:0];
      end
      return (mag >= 48'h800000) ? Q_MIN : -mag[23:0];
   endfunction

   // magnitude of a component, 24 bits unsigned
   function automatic logic [23:0] abs_q(input q_type v);
      return v[23] ? 24'(-v) : 24'(v);
   endfunction

   // negation, saturated
   function automatic q_type neg_sat(input q_type v);
      return (v == Q_MIN) ? Q_MAX : -v;
   endfunction

endpackage
`default_nettype wire

### rtl/particle_motion_step.sv
// particle_motion_step: one particle's position, velocity and force accumulator.
//
// Input channel req_*: opcode plus a Q15.8 vector. Add force saturates the vector
// into the accumulator, place overwrites the position, tick integrates one step.
// Every input word yields one rsp_* word with the position after it and, for a
// tick, flags for speed limiting and a wall bounce.
// A force, place or unused-opcode word goes straight to the result step. A tick
// adds force to velocity, sums the squared speed and compares it with the limit
// squared; a tick that limits the speed then runs a 24-step square root and
// three 48-step divides on the shared compare/subtract unit, each after a pass
// through the shared 24x24 multiplier; every tick then updates position, decays
// velocity and bounces. The block handles one word at a time; req_stall is high
// from acceptance until the result is loaded into the output register.
// A finished result sits in the output register while rsp_stall is high; the
// next input word can be accepted meanwhile, but its result waits for the
// register to drain.
// csr_*: write-only register port; the user writes it only while the block is
// idle (not enforced). reset (synchronous) clears position, velocity, force and
// all registers to their defaults and empties the output register.
`default_nettype none
module particle_motion_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [23:0] req_vec_x,
   input  wire logic signed [23:0] req_vec_y,
   input  wire logic signed [23:0] req_vec_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_pos_x,
   output logic signed [23:0]      rsp_pos_y,
   output logic signed [23:0]      rsp_pos_z,
   output logic                    rsp_speed_clamped,
   output logic                    rsp_wall_hit,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_VADD, S_SQ, S_CMP, S_SQRT, S_MULL, S_DIV,
      S_POS, S_DECAY, S_BNC, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       clamp_ff, clamp_in;
   logic       hit_ff, hit_in;

   pms_pkg::q_type pos_ff[3], pos_in[3];
   pms_pkg::q_type vel_ff[3], vel_in[3];
   pms_pkg::q_type frc_ff[3], frc_in[3];
   pms_pkg::q_type vec[3];

   // configuration
   logic [22:0]    limit_ff, limit_in;
   logic [16:0]    decay_ff, decay_in;
   logic [22:0]    radius_ff, radius_in;
   pms_pkg::q_type left_ff, left_in, top_ff, top_in;
   pms_pkg::q_type right_ff, right_in, bottom_ff, bottom_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   pms_pkg::q_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic           rsp_clamp_ff, rsp_clamp_in, rsp_hit_ff, rsp_hit_in;

   // datapath registers
   logic [47:0] prod_ff, prod_in;
   logic [47:0] acc_ff, acc_in;
   logic [47:0] res_ff, res_in;
   logic [47:0] bit_ff, bit_in;
   logic [47:0] quo_ff, quo_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] div_s_ff, div_s_in;

   // shared multiplier and compare/subtract unit
   logic [23:0] mul_a, mul_b;
   logic [47:0] sub_a, sub_b;
   logic [48:0] diff;
   logic        sub_ge;
   logic [1:0]  sel_idx;
   pms_pkg::q_type sel_v;
   logic [24:0] div_shift;
   logic [1:0]  dec_idx;

   // wall geometry
   logic signed [25:0] lo_w[2], hi_w[2], p_w[2];

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_pos_z         = rsp_z_ff;
   assign rsp_speed_clamped = rsp_clamp_ff;
   assign rsp_wall_hit      = rsp_hit_ff;

   // velocity component feeding the multiplier
   assign sel_idx = (state_ff == S_MULL) ? idx_ff : cnt_ff[1:0];
   always_comb begin
      case (sel_idx)
         2'd0:    sel_v = vel_ff[0];
         2'd1:    sel_v = vel_ff[1];
         default: sel_v = vel_ff[2];
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            if (cnt_ff == pms_pkg::SQ_LAST) begin
               mul_a = {1'b0, limit_ff};
               mul_b = {1'b0, limit_ff};
            end else begin
               mul_a = pms_pkg::abs_q(sel_v);
               mul_b = pms_pkg::abs_q(sel_v);
            end
         end
         S_MULL: begin
            mul_a = pms_pkg::abs_q(sel_v);
            mul_b = {1'b0, limit_ff};
         end
         S_DECAY: begin
            mul_a = pms_pkg::abs_q(sel_v);
            mul_b = {7'b0, decay_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // compare/subtract operand select: square root step or divide step
   assign div_shift = {rem_ff, quo_ff[47]};
   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = acc_ff;
         sub_b = res_ff | bit_ff;
      end else begin
         sub_a = {23'b0, div_shift};
         sub_b = {24'b0, div_s_ff};
      end
   end
   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = ~diff[48];

   assign dec_idx = cnt_ff[1:0] - 2'd1;

   // inset walls, x then y
   always_comb begin
      lo_w[0] = {{2{left_ff[23]}}, left_ff} + $signed({3'b0, radius_ff});
      hi_w[0] = {{2{right_ff[23]}}, right_ff} - $signed({3'b0, radius_ff});
      lo_w[1] = {{2{top_ff[23]}}, top_ff} + $signed({3'b0, radius_ff});
      hi_w[1] = {{2{bottom_ff[23]}}, bottom_ff} - $signed({3'b0, radius_ff});
      p_w[0]  = {{2{pos_ff[0][23]}}, pos_ff[0]};
      p_w[1]  = {{2{pos_ff[1][23]}}, pos_ff[1]};
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      clamp_in     = clamp_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      frc_in       = frc_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_s_in     = div_s_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_clamp_in = rsp_clamp_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               clamp_in = 1'b0;
               hit_in   = 1'b0;
               state_in = S_OUT;
               case (req_opcode)
                  pms_pkg::OP_FORCE: begin
                     for (int i = 0; i < 3; i++) begin
                        frc_in[i] = pms_pkg::sat_add(frc_ff[i], vec[i]);
                     end
                  end
                  pms_pkg::OP_PLACE: begin
                     for (int i = 0; i < 3; i++) begin
                        pos_in[i] = vec[i];
                     end
                  end
                  pms_pkg::OP_TICK: begin
                     state_in = S_VADD;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         // velocity += force
         S_VADD: begin
            for (int i = 0; i < 3; i++) begin
               vel_in[i] = pms_pkg::sat_add(vel_ff[i], frc_ff[i]);
            end
            acc_in   = '0;
            cnt_in   = '0;
            state_in = S_SQ;
         end

         // squared speed, then limit squared into prod
         S_SQ: begin
            if (cnt_ff != '0) begin
               acc_in = acc_ff + prod_ff;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == pms_pkg::SQ_LAST) begin
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (acc_ff > prod_ff) begin
               clamp_in = 1'b1;
               res_in   = '0;
               bit_in   = pms_pkg::SQRT_BIT0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               state_in = S_POS;
            end
         end

         // one result bit per cycle
         S_SQRT: begin
            if (sub_ge) begin
               acc_in = diff[47:0];
               res_in = (res_ff >> 1) | bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == pms_pkg::SQRT_LAST) begin
               div_s_in = (res_in[23:0] == '0) ? 24'd1 : res_in[23:0];
               idx_in   = '0;
               cnt_in   = '0;
               state_in = S_MULL;
            end
         end

         // |v| * limit, then load the dividend
         S_MULL: begin
            if (cnt_ff == '0) begin
               cnt_in = 6'd1;
            end else begin
               quo_in   = prod_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end

         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            rem_in = sub_ge ? diff[23:0] : div_shift[23:0];
            quo_in = {quo_ff[46:0], sub_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == pms_pkg::DIV_LAST) begin
               vel_in[idx_ff] = pms_pkg::sat_mag(vel_ff[idx_ff][23], quo_in);
               cnt_in = '0;
               if (idx_ff == 2'd2) begin
                  state_in = S_POS;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_MULL;
               end
            end
         end

         // position += velocity
         S_POS: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i] = pms_pkg::sat_add(pos_ff[i], vel_ff[i]);
            end
            cnt_in   = '0;
            state_in = S_DECAY;
         end

         // velocity *= decay, one component per cycle
         S_DECAY: begin
            if (cnt_ff != '0) begin
               vel_in[dec_idx] = pms_pkg::sat_mag(vel_ff[dec_idx][23],
                                                  {16'b0, prod_ff[47:16]});
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == pms_pkg::SQ_LAST) begin
               state_in = S_BNC;
            end
         end

         // wall bounce in x and y, clear force
         S_BNC: begin
            for (int a = 0; a < 2; a++) begin
               if (p_w[a] < lo_w[a] || p_w[a] > hi_w[a]) begin
                  pos_in[a] = pms_pkg::sat_wide((p_w[a] < lo_w[a]) ? lo_w[a] : hi_w[a]);
                  vel_in[a] = pms_pkg::neg_sat(vel_ff[a]);
                  hit_in    = 1'b1;
               end
            end
            for (int i = 0; i < 3; i++) begin
               frc_in[i] = '0;
            end
            state_in = S_OUT;
         end

         // load the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pos_ff[0];
               rsp_y_in     = pos_ff[1];
               rsp_z_in     = pos_ff[2];
               rsp_clamp_in = clamp_ff;
               rsp_hit_in   = hit_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      limit_in  = limit_ff;
      decay_in  = decay_ff;
      radius_in = radius_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pms_pkg::REG_SPEED_LIMIT: limit_in  = csr_wdata[22:0];
            pms_pkg::REG_DECAY:       decay_in  = csr_wdata[16:0];
            pms_pkg::REG_RADIUS:      radius_in = csr_wdata[22:0];
            pms_pkg::REG_LEFT:        left_in   = csr_wdata;
            pms_pkg::REG_TOP:         top_in    = csr_wdata;
            pms_pkg::REG_RIGHT:       right_in  = csr_wdata;
            pms_pkg::REG_BOTTOM:      bottom_in = csr_wdata;
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   // state, particle state, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         clamp_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
         limit_ff     <= pms_pkg::RST_SPEED_LIMIT;
         decay_ff     <= pms_pkg::RST_DECAY;
         radius_ff    <= pms_pkg::RST_RADIUS;
         left_ff      <= pms_pkg::RST_LEFT;
         top_ff       <= pms_pkg::RST_TOP;
         right_ff     <= pms_pkg::RST_RIGHT;
         bottom_ff    <= pms_pkg::RST_BOTTOM;
         rsp_valid_ff <= 1'b0;
         rsp_x_ff     <= '0;
         rsp_y_ff     <= '0;
         rsp_z_ff     <= '0;
         rsp_clamp_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         clamp_ff     <= clamp_in;
         hit_ff       <= hit_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         frc_ff       <= frc_in;
         limit_ff     <= limit_in;
         decay_ff     <= decay_in;
         radius_ff    <= radius_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_z_ff     <= rsp_z_in;
         rsp_clamp_ff <= rsp_clamp_in;
         rsp_hit_ff   <= rsp_hit_in;
      end
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_s_ff <= div_s_in;
   end

`ifndef SYNTH
   // non-tick words go straight to the result step
   a_short_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_opcode != pms_pkg::OP_TICK)
      |=> (state_ff == S_OUT))
      else $error("non-tick word did not go to result step");

   // no limiting unless the squared speed exceeds the limit squared
   a_no_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && !(acc_ff > prod_ff)) |=> (state_ff == S_POS && !clamp_ff))
      else $error("speed limited without exceeding the limit");

   // divide remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < div_s_ff))
      else $error("divide remainder out of range");

   // force accumulator is empty after a tick
   a_force_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BNC)
      |=> (frc_ff[0] == '0 && frc_ff[1] == '0 && frc_ff[2] == '0))
      else $error("force accumulator not cleared by tick");

   // a free output register is loaded and the block returns to idle
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into free output register");
`endif

endmodule
`default_nettype wire
